// ===== src/jesc_pkg.sv =====
// ----------------------------------------------------------------------------
// jesc_pkg
// Shared types, codes and helpers of the JPEG entropy symbol coder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jesc_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_DC    = 2'd1,
    CMD_AC    = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned MAX_CODE_LEN  = 16;
  localparam logic signed [10:0] COEF_MIN = -11'sd1023;

  // Table used by each component: luma on its own, chroma shared
  localparam logic [1:0] AC_TABLE_OF [4] = '{2'd0, 2'd1, 2'd1, 2'd1};
  localparam logic [1:0] DC_TABLE_OF [4] = '{2'd2, 2'd3, 2'd3, 2'd3};

  // Result of the symbol stage for one request
  typedef struct packed {
    logic                emit;       // request gives a result
    logic                pred_we;    // DC request: store new predictor
    logic signed [10:0]  coef;       // clamped coefficient
    logic [1:0]          table_idx;  // Huffman table to look up
    logic                table_ok;   // table exists
    logic [7:0]          symbol;     // entry within the table
    logic [10:0]         amp_bits;
    logic [3:0]          amp_len;
  } lookup_t;

  // Size category: bit length of a magnitude
  function automatic logic [3:0] size_cat(input logic [10:0] mag);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) s = 4'(i + 1);
    end
    return s;
  endfunction

endpackage

// ===== src/jesc_ram.sv =====
// ----------------------------------------------------------------------------
// jesc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jesc_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/jesc_symbol.sv =====
// ----------------------------------------------------------------------------
// jesc_symbol
// Symbol stage: clamps the coefficient, forms the DC difference, size
// category, amplitude bits, Huffman symbol and table selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jesc_symbol import jesc_pkg::*; #(
  parameter int unsigned NUM_COMPONENTS = 3,
  parameter int unsigned NUM_TABLES     = 4
) (
  input  cmd_e               cmd_i,
  input  logic [1:0]         component_i,
  input  logic [3:0]         run_i,
  input  logic signed [10:0] coef_i,
  input  logic signed [10:0] pred_i,
  output lookup_t            lookup_o
);

  logic signed [10:0] coef_c;
  logic signed [11:0] val;
  logic signed [11:0] val_m1;
  logic [10:0]        mag;
  logic [3:0]         cat;
  logic [3:0]         coef_cat;
  logic [10:0]        mask;
  logic               comp_ok;

  // Clamp to +/-1023: only the most negative code is out of range
  assign coef_c = (coef_i < COEF_MIN) ? COEF_MIN : coef_i;

  // Value to code: DC difference or the AC value itself
  assign val = (cmd_i == CMD_DC) ? (12'(coef_c) - 12'(pred_i)) : 12'(coef_c);

  assign mag      = val[11] ? 11'(-val) : val[10:0];
  assign cat      = size_cat(mag);
  assign coef_cat = size_cat(coef_c[10] ? 11'(-coef_c) : 11'(coef_c));

  // Negative values send the low category bits of value minus one
  assign val_m1 = val - 12'sd1;
  assign mask   = ~(11'h7FF << cat);

  assign comp_ok = {1'b0, component_i} < 3'(NUM_COMPONENTS);

  always_comb begin
    lookup_o          = '0;
    lookup_o.coef     = coef_c;
    lookup_o.amp_len  = cat;
    lookup_o.amp_bits = val[11] ? (val_m1[10:0] & mask) : val[10:0];
    lookup_o.emit     = comp_ok && (cmd_i == CMD_DC || cmd_i == CMD_AC);
    lookup_o.pred_we  = comp_ok && (cmd_i == CMD_DC);
    if (cmd_i == CMD_DC) begin
      lookup_o.table_idx = DC_TABLE_OF[component_i];
      lookup_o.symbol    = {4'd0, cat};
    end else begin
      lookup_o.table_idx = AC_TABLE_OF[component_i];
      lookup_o.symbol    = {run_i, coef_cat};
    end
    lookup_o.table_ok = {1'b0, lookup_o.table_idx} < 3'(NUM_TABLES);
  end

endmodule

// ===== src/jpeg_entropy_symbol_coder.sv =====
// ----------------------------------------------------------------------------
// jpeg_entropy_symbol_coder
// Baseline JPEG entropy symbol stage: Huffman table lookup and amplitude bits.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: table writes, DC coefficients,
//   AC run/value pairs and predictor clears. Each DC or AC request with a
//   valid component gives one result on m_axis (code, code length,
//   amplitude bits, size category); the other requests give none.
//   Throughput is one request per cycle while the receiver does not stall.
//   A request's result reaches m_axis_tvalid through the input register,
//   the table RAM's registered read, then the output register.
//   A table write takes effect for any lookup accepted after it.
//   Reset clears the pipeline and the DC predictors; the Huffman tables are
//   undefined until written and need no clearing pass.
//   When the receiver stalls, the output register holds its result and
//   m_axis_tready reaches every stage in the same cycle through the ready
//   chain; empty stages still fill, so s_axis_tready drops only once every
//   stage is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_entropy_symbol_coder import jesc_pkg::*; #(
  parameter int unsigned NUM_COMPONENTS = 3,
  parameter int unsigned NUM_TABLES     = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cmd, [3:2] component, [5:4] table_sel, [13:6] symbol,
  // [29:14] code_word, [34:30] code_length, [38:35] run, [49:39] coef
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] huff_code, [20:16] huff_len, [31:21] amp_bits, [35:32] amp_len
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned TSW   = $clog2(NUM_TABLES);
  localparam int unsigned DEPTH = NUM_TABLES * TABLE_ENTRIES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = 21;

  // Input register
  logic        s1_valid_q;
  logic [49:0] s1_data_q;

  cmd_e               s1_cmd;
  logic [1:0]         s1_comp;
  logic [1:0]         s1_tsel;
  logic [7:0]         s1_sym;
  logic [15:0]        s1_cw;
  logic [4:0]         s1_cl;
  logic [3:0]         s1_run;
  logic signed [10:0] s1_coef;

  assign s1_cmd  = cmd_e'(s1_data_q[1:0]);
  assign s1_comp = s1_data_q[3:2];
  assign s1_tsel = s1_data_q[5:4];
  assign s1_sym  = s1_data_q[13:6];
  assign s1_cw   = s1_data_q[29:14];
  assign s1_cl   = s1_data_q[34:30];
  assign s1_run  = s1_data_q[38:35];
  assign s1_coef = s1_data_q[49:39];

  // Lookup stage and output register
  logic        s2_valid_q;
  logic        s2_table_ok_q;
  logic [10:0] s2_amp_bits_q;
  logic [3:0]  s2_amp_len_q;
  logic        out_valid_q;
  logic [35:0] out_data_q;

  logic out_ready;
  logic s2_ready;
  logic s1_ready;
  logic s1_fire;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s2_ready      = !s2_valid_q || out_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s1_fire       = s1_valid_q && s2_ready;
  assign s_axis_tready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid) s1_data_q <= s_axis_tdata[49:0];
  end

  // DC predictors
  logic signed [10:0] pred_q [NUM_COMPONENTS];
  logic signed [10:0] pred_sel;

  always_comb begin
    pred_sel = '0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (s1_comp == 2'(i)) pred_sel = pred_q[i];
    end
  end

  lookup_t lookup;

  jesc_symbol #(
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .NUM_TABLES     (NUM_TABLES)
  ) u_symbol (
    .cmd_i       (s1_cmd),
    .component_i (s1_comp),
    .run_i       (s1_run),
    .coef_i      (s1_coef),
    .pred_i      (pred_sel),
    .lookup_o    (lookup)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) pred_q[i] <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        if (s1_cmd == CMD_CLEAR) begin
          pred_q[i] <= '0;
        end else if (lookup.pred_we && s1_comp == 2'(i)) begin
          pred_q[i] <= lookup.coef;
        end
      end
    end
  end

  // Huffman tables: {length, code} per entry
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  logic [4:0]    cl_sat;

  assign cl_sat    = (s1_cl > 5'(MAX_CODE_LEN)) ? 5'(MAX_CODE_LEN) : s1_cl;
  assign ram_we    = s1_fire && s1_cmd == CMD_WRITE && ({1'b0, s1_tsel} < 3'(NUM_TABLES));
  assign ram_waddr = {s1_tsel[TSW-1:0], s1_sym};
  assign ram_wdata = {cl_sat, s1_cw};
  assign ram_re    = s1_fire && lookup.emit;
  assign ram_raddr = {lookup.table_idx[TSW-1:0], lookup.symbol};

  jesc_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Lookup stage side data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_fire && lookup.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s2_table_ok_q <= lookup.table_ok;
      s2_amp_bits_q <= lookup.amp_bits;
      s2_amp_len_q  <= lookup.amp_len;
    end
  end

  // Output register; a missing table answers code and length zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_valid_q) begin
      out_data_q <= {s2_amp_len_q, s2_amp_bits_q,
                     s2_table_ok_q ? ram_rdata : {RW{1'b0}}};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_data_q};

  // Checks
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write and lookup in the same cycle");

  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(s1_valid_q))
    else $error("lookup stage filled without an input request");

  a_amp_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q[35:32] <= 4'd11)
    else $error("size category above 11");

  a_amp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[35:32] == 4'd0) |-> out_data_q[31:21] == 11'd0)
    else $error("amplitude bits set with category zero");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && s2_valid_q && out_valid_q))
    else $error("input stalled with an empty stage");

endmodule
